@@ rtl/rkmc_pkg.sv @@
// Shared constants and item layouts for the rotary knob mode controller.
package rkmc_pkg;

   // Threshold register
   localparam int unsigned THRESH_WIDTH = 16;
   localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

   // Detent step codes, 2-bit two's complement
   localparam logic signed [1:0] STEP_NONE = 2'sb00;
   localparam logic signed [1:0] STEP_CW   = 2'sb01;
   localparam logic signed [1:0] STEP_CCW  = 2'sb11;

   // Mode codes
   localparam logic MODE_SCROLL = 1'b0;
   localparam logic MODE_VOLUME = 1'b1;

   // Input item as packed in req_tdata (last field lowest)
   typedef struct packed {
      logic [4:0] pad;
      logic       button_n;
      logic       enc_b;
      logic       enc_a;
   } req_item_type;

   // Result item as packed in rsp_tdata (last field lowest)
   typedef struct packed {
      logic              pad;
      logic              mode_toggled;
      logic signed [1:0] volume_step;
      logic signed [1:0] scroll_step;
      logic              mute_pulse;
      logic              volume_mode;
   } rsp_item_type;

endpackage

@@ rtl/rotary_knob_mode_controller.sv @@
// Rotary knob mode controller: encoder decode, long-press mode toggle and mute.
//
// Each req item is one tick sample of the encoder A/B lines and the active-low
// knob button; each produces exactly one rsp item in the next cycle. An item is
// taken every clock (one item per cycle sustained): the decode is a single
// level of compare and increment logic between the knob state registers and
// the result register, and the result register lets a new item in while the
// previous result is still waiting, as long as rsp_tready drains it.
// A press start gives mute in volume mode; a press held for more ticks than the
// threshold register value toggles between scrolling and volume mode once per
// press. A rising edge of A gives +1 with B low and -1 with B high, routed to
// the step of the mode after this tick. The first item after reset only
// captures A. The hold counter is COUNT_WIDTH bits and saturates at its top.
module rotary_knob_mode_controller #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] enc_a, [1] enc_b, [2] button_n, [7:3] zero
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] volume_mode, [1] mute_pulse, [3:2] scroll_step,
                                    // [5:4] volume_step, [6] mode_toggled, [7] zero
   // Threshold register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int unsigned CMP_WIDTH =
      (COUNT_WIDTH > rkmc_pkg::THRESH_WIDTH) ? COUNT_WIDTH : rkmc_pkg::THRESH_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

   rkmc_pkg::req_item_type req_item;
   rkmc_pkg::rsp_item_type rsp_item_in, rsp_item_ff;

   logic [rkmc_pkg::THRESH_WIDTH-1:0] thresh_ff, thresh_in;
   logic                   held_ff, held_in;
   logic                   long_done_ff, long_done_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   last_a_ff, last_a_in;
   logic                   primed_ff, primed_in;
   logic                   mode_ff, mode_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   req_accept;
   logic                   mute;
   logic                   toggled;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic signed [1:0]      step;

   assign req_item   = rkmc_pkg::req_item_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Threshold register
   assign thresh_in = (csr_valid && csr_ready) ? csr_data : thresh_ff;

   // Saturating hold counter
   assign count_inc = (count_ff == COUNT_TOP) ? count_ff : count_ff + 1'b1;

   // Button and mode handling
   always_comb begin
      held_in      = held_ff;
      long_done_in = long_done_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      mute         = 1'b0;
      toggled      = 1'b0;
      if (req_item.button_n) begin
         held_in      = 1'b0;
         long_done_in = 1'b0;
         count_in     = '0;
      end else if (!held_ff) begin
         held_in      = 1'b1;
         long_done_in = 1'b0;
         count_in     = '0;
         mute         = (mode_ff == rkmc_pkg::MODE_VOLUME);
      end else begin
         count_in = count_inc;
         if ((CMP_WIDTH'(count_inc) > CMP_WIDTH'(thresh_ff)) && !long_done_ff) begin
            long_done_in = 1'b1;
            mode_in      = !mode_ff;
            toggled      = 1'b1;
         end
      end
   end

   // Encoder decode on rising edge of A
   always_comb begin
      step = rkmc_pkg::STEP_NONE;
      if (primed_ff && req_item.enc_a && !last_a_ff) begin
         step = req_item.enc_b ? rkmc_pkg::STEP_CCW : rkmc_pkg::STEP_CW;
      end
   end
   assign last_a_in = req_item.enc_a;
   assign primed_in = 1'b1;

   // Result assembly
   always_comb begin
      rsp_item_in              = '0;
      rsp_item_in.volume_mode  = mode_in;
      rsp_item_in.mute_pulse   = mute;
      rsp_item_in.scroll_step  = (mode_in == rkmc_pkg::MODE_SCROLL) ? step
                                                                    : rkmc_pkg::STEP_NONE;
      rsp_item_in.volume_step  = (mode_in == rkmc_pkg::MODE_VOLUME) ? step
                                                                    : rkmc_pkg::STEP_NONE;
      rsp_item_in.mode_toggled = toggled;
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= rkmc_pkg::LONG_PRESS_RESET;
         held_ff      <= 1'b0;
         long_done_ff <= 1'b0;
         count_ff     <= '0;
         last_a_ff    <= 1'b0;
         primed_ff    <= 1'b0;
         mode_ff      <= rkmc_pkg::MODE_SCROLL;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            held_ff      <= held_in;
            long_done_ff <= long_done_in;
            count_ff     <= count_in;
            last_a_ff    <= last_a_in;
            primed_ff    <= primed_in;
            mode_ff      <= mode_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

endmodule

@@ rtl/rkmc_checker.sv @@
// Port-level checks for the rotary knob mode controller, bound to the top level.
module rkmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   rkmc_pkg::rsp_item_type rsp_item;
   assign rsp_item = rkmc_pkg::rsp_item_type'(rsp_tdata);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // A detent goes to one destination only
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_item.scroll_step == rkmc_pkg::STEP_NONE ||
                     rsp_item.volume_step == rkmc_pkg::STEP_NONE)
      else $error("scroll and volume step both set");

   // Mute only in volume mode, and never on the tick of a toggle
   a_mute_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.mute_pulse |->
         rsp_item.volume_mode == rkmc_pkg::MODE_VOLUME && !rsp_item.mode_toggled)
      else $error("mute outside volume mode or with toggle");

   // No volume step in scrolling mode
   a_step_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.volume_mode == rkmc_pkg::MODE_SCROLL |->
         rsp_item.volume_step == rkmc_pkg::STEP_NONE)
      else $error("volume step in scrolling mode");

   // Each accepted item gives one result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

endmodule

bind rotary_knob_mode_controller rkmc_checker u_rkmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/rotary_knob_mode_controller_test.sv @@
// Self-checking testbench for the rotary knob mode controller: directed and random knob ticks.
module rotary_knob_mode_controller_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOLD_WIDTH  = 16;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          PLAN_LEN    = 23;
   localparam int          IDLE_PCT    = 27;

   // One row of the directed plan: a threshold write or a knob tick
   typedef struct packed {
      logic                   is_cfg;
      logic [15:0]            cfg_value;
      logic                   enc_a;
      logic                   enc_b;
      logic                   button_n;
      logic                   typed;
      rkmc_pkg::rsp_item_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [0] enc_a, [1] enc_b, [2] button_n, [7:3] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] volume_mode, [1] mute_pulse, [3:2] scroll_step,
                             // [5:4] volume_step, [6] mode_toggled, [7] zero
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // Knob state as the predictor sees it
   logic                  knob_pressed = 1'b0;
   logic                  long_done    = 1'b0;
   logic [HOLD_WIDTH-1:0] hold_ticks   = '0;
   logic                  prev_a       = 1'b0;
   logic                  a_primed     = 1'b0;
   logic                  knob_mode    = rkmc_pkg::MODE_SCROLL;
   logic [15:0]           lp_threshold = rkmc_pkg::LONG_PRESS_RESET;

   rkmc_pkg::rsp_item_type pending_results [$];
   int           failures        = 0;
   int           ticks_sent      = 0;
   int           results_seen    = 0;
   int           toggles_seen    = 0;
   int           mutes_seen      = 0;
   int           cycle_count     = 0;
   int           quad_pos        = 0;
   bit           idle_on         = 1'b1;
   bit           squeeze_request = 1'b0;

   rotary_knob_mode_controller #(.COUNT_WIDTH(HOLD_WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Expected result of one tick; advances the predictor's knob state
   function automatic rkmc_pkg::rsp_item_type predict_tick(input logic a, input logic b,
                                                           input logic bn);
      rkmc_pkg::rsp_item_type r;
      logic signed [1:0]      detent;
      r      = '0;
      detent = rkmc_pkg::STEP_NONE;
      if (!bn) begin
         if (!knob_pressed) begin
            knob_pressed = 1'b1;
            hold_ticks   = '0;
            long_done    = 1'b0;
            r.mute_pulse = (knob_mode == rkmc_pkg::MODE_VOLUME);
         end else begin
            if (hold_ticks != '1)
               hold_ticks++;
            if (hold_ticks > lp_threshold && !long_done) begin
               long_done      = 1'b1;
               knob_mode      = ~knob_mode;
               r.mode_toggled = 1'b1;
            end
         end
      end else begin
         knob_pressed = 1'b0;
         hold_ticks   = '0;
         long_done    = 1'b0;
      end
      // rising edge of A only, and never on the very first sample
      if (a_primed && a && !prev_a)
         detent = b ? rkmc_pkg::STEP_CCW : rkmc_pkg::STEP_CW;
      prev_a   = a;
      a_primed = 1'b1;
      r.volume_mode = knob_mode;
      if (knob_mode == rkmc_pkg::MODE_VOLUME)
         r.volume_step = detent;
      else
         r.scroll_step = detent;
      return r;
   endfunction

   function automatic rkmc_pkg::rsp_item_type res(input logic mode, input logic mute,
                                                  input logic signed [1:0] scroll,
                                                  input logic signed [1:0] volume,
                                                  input logic toggled);
      rkmc_pkg::rsp_item_type r;
      r              = '0;
      r.volume_mode  = mode;
      r.mute_pulse   = mute;
      r.scroll_step  = scroll;
      r.volume_step  = volume;
      r.mode_toggled = toggled;
      return r;
   endfunction

   function automatic plan_row_type tk(input logic a, input logic b, input logic bn);
      plan_row_type p;
      p          = '0;
      p.enc_a    = a;
      p.enc_b    = b;
      p.button_n = bn;
      return p;
   endfunction

   function automatic plan_row_type tkx(input logic a, input logic b, input logic bn,
                                        input rkmc_pkg::rsp_item_type want);
      plan_row_type p;
      p       = tk(a, b, bn);
      p.typed = 1'b1;
      p.want  = want;
      return p;
   endfunction

   function automatic plan_row_type thr(input logic [15:0] v);
      plan_row_type p;
      p           = '0;
      p.is_cfg    = 1'b1;
      p.cfg_value = v;
      return p;
   endfunction

   // Offer one tick; called and returning at a falling edge
   task automatic send_tick(input logic a, input logic b, input logic bn,
                            input logic typed, input rkmc_pkg::rsp_item_type want);
      rkmc_pkg::req_item_type item;
      rkmc_pkg::rsp_item_type calc;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      calc = predict_tick(a, b, bn);
      pending_results.push_back(typed ? want : calc);
      item          = '0;
      item.enc_a    = a;
      item.enc_b    = b;
      item.button_n = bn;
      req_tdata  <= item;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
      @(negedge clock);
   endtask

   // Threshold write, only once every outstanding result is back
   task automatic write_threshold(input logic [15:0] v);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid    <= 1'b0;
      lp_threshold = v;
   endtask

   // Quadrature walk with button runs; hold_all keeps the button down throughout
   task automatic knob_phase(input int n_items, input int longest, input bit hold_all);
      int   run_left;
      int   mv;
      logic pressed;
      logic a;
      logic b;
      logic bn;
      run_left = 0;
      pressed  = 1'b0;
      for (int i = 0; i < n_items; i++) begin
         if (hold_all) begin
            pressed = 1'b1;
         end else if (run_left == 0) begin
            pressed  = ~pressed;
            run_left = $urandom_range(longest, 1);
         end
         if (!hold_all)
            run_left--;
         mv = $urandom_range(99);
         if (mv < 35)
            quad_pos = (quad_pos + 1) % 4;
         else if (mv < 60)
            quad_pos = (quad_pos + 3) % 4;
         a  = (quad_pos == 1 || quad_pos == 2);
         b  = (quad_pos == 2 || quad_pos == 3);
         bn = ~pressed;
         // occasional contact bounce and glitches
         if (!hold_all && $urandom_range(99) < 8) begin
            a  = 1'($urandom_range(1));
            b  = 1'($urandom_range(1));
            bn = 1'($urandom_range(1));
         end
         send_tick(a, b, bn, 1'b0, '0);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int held;
      held       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_request) begin
            held            = 400;
            squeeze_request = 1'b0;
         end
         if (held > 0) begin
            held--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      rkmc_pkg::rsp_item_type got;
      rkmc_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result item %h with no tick outstanding", rsp_tdata);
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("volume_mode", want.volume_mode, got.volume_mode);
            check_field("mute_pulse", want.mute_pulse, got.mute_pulse);
            check_field("scroll_step", want.scroll_step, got.scroll_step);
            check_field("volume_step", want.volume_step, got.volume_step);
            check_field("mode_toggled", want.mode_toggled, got.mode_toggled);
            toggles_seen += got.mode_toggled;
            mutes_seen   += got.mute_pulse;
         end
      end
   end

   // Stimulus
   initial begin
      plan_row_type           plan [PLAN_LEN];
      rkmc_pkg::rsp_item_type quiet;
      logic [15:0]            phase_thr [6];
      int                     lim;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      quiet      = res(rkmc_pkg::MODE_SCROLL, 1'b0, rkmc_pkg::STEP_NONE, rkmc_pkg::STEP_NONE,
                       1'b0);
      plan = '{
         // first sample only captures A, then a falling edge that is ignored
         tkx(1, 0, 1, quiet),
         tkx(0, 0, 1, quiet),
         tkx(1, 0, 1, res(rkmc_pkg::MODE_SCROLL, 1'b0, rkmc_pkg::STEP_CW,
                          rkmc_pkg::STEP_NONE, 1'b0)),
         tk (0, 1, 1),
         tkx(1, 1, 1, res(rkmc_pkg::MODE_SCROLL, 1'b0, rkmc_pkg::STEP_CCW,
                          rkmc_pkg::STEP_NONE, 1'b0)),
         // press in scrolling mode: no mute
         tkx(1, 1, 0, quiet),
         tk (0, 0, 0),
         tk (0, 0, 1),
         // zero threshold: long press on the second tick of the press
         thr(16'd0),
         tk (0, 0, 0),
         tkx(1, 0, 0, res(rkmc_pkg::MODE_VOLUME, 1'b0, rkmc_pkg::STEP_NONE,
                          rkmc_pkg::STEP_CW, 1'b1)),
         tk (1, 0, 0),
         tk (0, 1, 1),
         tkx(1, 1, 0, res(rkmc_pkg::MODE_VOLUME, 1'b1, rkmc_pkg::STEP_NONE,
                          rkmc_pkg::STEP_CCW, 1'b0)),
         tkx(0, 0, 0, res(rkmc_pkg::MODE_SCROLL, 1'b0, rkmc_pkg::STEP_NONE,
                          rkmc_pkg::STEP_NONE, 1'b1)),
         tk (0, 0, 1),
         // threshold of one
         thr(16'd1),
         tk (0, 0, 0),
         tk (0, 0, 0),
         tkx(0, 0, 0, res(rkmc_pkg::MODE_VOLUME, 1'b0, rkmc_pkg::STEP_NONE,
                          rkmc_pkg::STEP_NONE, 1'b1)),
         tk (1, 1, 0),
         tk (0, 0, 1),
         thr(16'hFFFF)
      };
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      foreach (plan[i]) begin
         if (plan[i].is_cfg)
            write_threshold(plan[i].cfg_value);
         else
            send_tick(plan[i].enc_a, plan[i].enc_b, plan[i].button_n, plan[i].typed,
                      plan[i].want);
      end

      // long unbroken press at the top threshold: no toggle
      idle_on = 1'b0;
      knob_phase(60, 0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1, 1'b0, '0);
      idle_on = 1'b1;

      // random phases over several thresholds
      phase_thr = '{16'd3, 16'd1, 16'd0, 16'($urandom_range(40, 2)), 16'd12,
                    16'($urandom_range(25, 4))};
      for (int p = 0; p < 6; p++) begin
         write_threshold(phase_thr[p]);
         lim = 2 * phase_thr[p] + 4;
         if (p == 1)
            squeeze_request = 1'b1;
         idle_on = (p != 3);
         knob_phase(300, lim, 1'b0);
      end
      idle_on = 1'b1;
      write_threshold(rkmc_pkg::LONG_PRESS_RESET);

      // drain
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Knob run: %0d ticks sent, %0d results checked, %0d mode toggles, %0d mutes.",
               ticks_sent, results_seen, toggles_seen, mutes_seen);
      $display("Covered zero, low, random and top thresholds, a long press, stalls.");
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rkmc_pkg.sv
rtl/rotary_knob_mode_controller.sv
rtl/rkmc_checker.sv
sim/rotary_knob_mode_controller_test.sv
